@@ src/tllbp_pkg.sv @@
package tllbp_pkg;

    // Default table geometry
    localparam int unsigned HIST_ENTRIES_DEF    = 1024;
    localparam int unsigned HIST_BITS_DEF       = 10;
    localparam int unsigned PATTERN_ENTRIES_DEF = 1024;

    // Field widths
    localparam int unsigned PC_W  = 64;
    localparam int unsigned CTR_W = 2;

    // Branch address bits below the slot index
    localparam int unsigned PC_ALIGN = 2;

    // Operation codes
    typedef enum logic {
        FUNC_PREDICT = 1'b0,
        FUNC_UPDATE  = 1'b1
    } t_func;

    // Saturating counter limits
    localparam logic [CTR_W-1:0] CTR_MIN = 2'd0;
    localparam logic [CTR_W-1:0] CTR_MAX = 2'd3;

endpackage

@@ src/tllbp_req_if.sv @@
interface tllbp_req_if import tllbp_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            func;
    logic [PC_W-1:0] pc;
    logic            taken;

    modport source (output valid, output func, output pc, output taken, input ready);
    modport sink   (input valid, input func, input pc, input taken, output ready);
endinterface

@@ src/tllbp_rsp_if.sv @@
interface tllbp_rsp_if import tllbp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             predict_taken;
    logic [CTR_W-1:0] confidence;

    modport source (output valid, output predict_taken, output confidence, input ready);
    modport sink   (input valid, input predict_taken, input confidence, output ready);
endinterface

@@ src/tllbp_init.sv @@
module tllbp_init #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    output logic                     o_busy,
    output logic [$clog2(DEPTH)-1:0] o_idx
);

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

    logic             r_busy;
    logic [IDX_W-1:0] r_idx;

    // Sweep every entry once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy) begin
            r_idx <= r_idx + 1'b1;
            if (r_idx == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_idx  = r_idx;

endmodule

@@ src/two_level_local_branch_predictor.sv @@
// Channel  Dir  Interface     Payload
// i_req    in   tllbp_req_if  func, pc[63:0], taken
// o_rsp    out  tllbp_rsp_if  predict_taken, confidence[1:0]
//
// One beat accepted per cycle unless stalled; a predict result passes the history read
// at acceptance, the counter read and the result register. Updates give none.
// After reset the tables are swept one entry a cycle over max(HIST_ENTRIES,
// PATTERN_ENTRIES) indices (1024 by default); i_req.ready stays low meanwhile.
// A stalled o_rsp freezes the whole pipeline, and i_req.ready follows it.
// Back-to-back hits on one slot or counter are served by bypass of the last write.
module two_level_local_branch_predictor
    import tllbp_pkg::*;
#(
    parameter int unsigned HIST_ENTRIES    = HIST_ENTRIES_DEF,
    parameter int unsigned HIST_BITS       = HIST_BITS_DEF,
    parameter int unsigned PATTERN_ENTRIES = PATTERN_ENTRIES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tllbp_req_if.sink    i_req,
    tllbp_rsp_if.source  o_rsp
);

    localparam int unsigned SLOT_W  = $clog2(HIST_ENTRIES);
    localparam int unsigned CI_W    = $clog2(PATTERN_ENTRIES);
    localparam int unsigned CLR_N   = (HIST_ENTRIES > PATTERN_ENTRIES) ?
                                      HIST_ENTRIES : PATTERN_ENTRIES;
    localparam int unsigned CLR_W   = $clog2(CLR_N);

    // Sweep sequencer
    logic             clr_busy;
    logic [CLR_W-1:0] clr_idx;

    tllbp_init #(
        .DEPTH (CLR_N)
    ) u_init (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_busy  (clr_busy),
        .o_idx   (clr_idx)
    );

    logic en;
    logic acc;

    assign en          = !o_rsp.valid || o_rsp.ready;
    assign i_req.ready = en && !clr_busy;
    assign acc         = i_req.valid && i_req.ready;

    // Memories
    logic [HIST_BITS-1:0] hist_mem [HIST_ENTRIES];
    logic [CTR_W-1:0]     pat_mem  [PATTERN_ENTRIES];

    // Stage 1 registers
    logic              r_s1_vld;
    logic              r_s1_func;
    logic              r_s1_taken;
    logic [SLOT_W-1:0] r_s1_slot;
    logic [HIST_BITS-1:0] r_hist_rd;

    // Stage 2 registers
    logic              r_s2_vld;
    logic              r_s2_func;
    logic              r_s2_taken;
    logic [CI_W-1:0]   r_s2_ci;
    logic [CTR_W-1:0]  r_pat_rd;

    // Last-write bypass registers
    logic                 r_hw_vld;
    logic [SLOT_W-1:0]    r_hw_slot;
    logic [HIST_BITS-1:0] r_hw_data;
    logic                 r_pw_vld;
    logic [CI_W-1:0]      r_pw_idx;
    logic [CTR_W-1:0]     r_pw_data;

    // Result register
    logic             r_out_vld;
    logic             r_out_tk;
    logic [CTR_W-1:0] r_out_conf;

    logic [SLOT_W-1:0]         in_slot;
    logic [HIST_BITS-1:0]      hist_s1;
    logic [HIST_BITS-1:0]      hist_new;
    logic [HIST_BITS+CI_W-1:0] hist_ext;
    logic [CI_W-1:0]           ci_s1;
    logic                      hist_we;
    logic [CTR_W-1:0]          ctr_s2;
    logic [CTR_W-1:0]          ctr_new;
    logic                      pat_we;

    // Slot from word address
    assign in_slot = i_req.pc[SLOT_W+PC_ALIGN-1:PC_ALIGN];

    // Stage 1: history with bypass, shifted history, counter index
    assign hist_s1  = (r_hw_vld && (r_hw_slot == r_s1_slot)) ? r_hw_data : r_hist_rd;
    assign hist_new = (hist_s1 << 1) | HIST_BITS'(r_s1_taken);
    assign hist_ext = {{CI_W{1'b0}}, hist_s1};
    assign ci_s1    = hist_ext[CI_W-1:0];
    assign hist_we  = en && r_s1_vld && (r_s1_func == FUNC_UPDATE);

    // Stage 2: counter with bypass, saturating step
    assign ctr_s2 = (r_pw_vld && (r_pw_idx == r_s2_ci)) ? r_pw_data : r_pat_rd;
    always_comb begin
        ctr_new = ctr_s2;
        if (r_s2_taken) begin
            if (ctr_s2 != CTR_MAX) begin
                ctr_new = ctr_s2 + 1'b1;
            end
        end else begin
            if (ctr_s2 != CTR_MIN) begin
                ctr_new = ctr_s2 - 1'b1;
            end
        end
    end
    assign pat_we = en && r_s2_vld && (r_s2_func == FUNC_UPDATE);

    // History memory: sweep or update write, registered read
    always_ff @(posedge i_clk) begin
        if (clr_busy) begin
            hist_mem[clr_idx[SLOT_W-1:0]] <= '1;
        end else if (hist_we) begin
            hist_mem[r_s1_slot] <= hist_new;
        end
        if (en) begin
            r_hist_rd <= hist_mem[in_slot];
        end
    end

    // Pattern memory: sweep or update write, registered read
    always_ff @(posedge i_clk) begin
        if (clr_busy) begin
            pat_mem[clr_idx[CI_W-1:0]] <= CTR_MAX;
        end else if (pat_we) begin
            pat_mem[r_s2_ci] <= ctr_new;
        end
        if (en) begin
            r_pat_rd <= pat_mem[ci_s1];
        end
    end

    // Pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_hw_vld  <= 1'b0;
            r_pw_vld  <= 1'b0;
        end else if (en) begin
            r_s1_vld  <= acc;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= r_s2_vld && (r_s2_func == FUNC_PREDICT);
            r_hw_vld  <= hist_we;
            r_pw_vld  <= pat_we;
        end
    end

    // Pipeline payload; hold while stalled
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_func  <= i_req.func;
            r_s1_taken <= i_req.taken;
            r_s1_slot  <= in_slot;
            r_s2_func  <= r_s1_func;
            r_s2_taken <= r_s1_taken;
            r_s2_ci    <= ci_s1;
            r_hw_slot  <= r_s1_slot;
            r_hw_data  <= hist_new;
            r_pw_idx   <= r_s2_ci;
            r_pw_data  <= ctr_new;
            r_out_tk   <= ctr_s2[CTR_W-1];
            r_out_conf <= ctr_s2;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.predict_taken = r_out_tk;
    assign o_rsp.confidence    = r_out_conf;

    // Checks
    a_sweep_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> clr_busy)
        else $error("table sweep not started after reset");

    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !i_req.ready)
        else $error("beat accepted during table sweep");

    a_no_write_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |-> (!hist_we && !pat_we))
        else $error("table written while pipeline stalled");

    a_predict_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_s2_vld && (r_s2_func == FUNC_PREDICT)) |=> o_rsp.valid)
        else $error("predict result lost");

    a_taken_matches_conf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.predict_taken == o_rsp.confidence[CTR_W-1]))
        else $error("prediction disagrees with counter");

endmodule
